### hw/rtl/ebc_pkg.sv
// ebc_pkg: shared types, constants and decode for the bus-cycle cpu core
// no dependencies
`timescale 1ns / 1ps
package ebc_pkg;

   localparam logic [3:0] TAIL = 4'd10;

   typedef enum logic [5:0] {
      K_ORA, K_AND, K_EOR, K_ADC, K_STA, K_LDA, K_CMP, K_SBC,
      K_ASL, K_ROL, K_LSR, K_ROR, K_STX, K_LDX, K_DEC, K_INC,
      K_BIT, K_STY, K_LDY, K_CPY, K_CPX, K_JMP, K_JMPI, K_JSR, K_RTS,
      K_RTI, K_PHA, K_PHP, K_PLA, K_PLP, K_BRANCH, K_IMPL, K_BAD
   } kind_type;

   typedef enum logic [3:0] {
      M_IMP, M_ACC, M_IMM, M_ZP, M_ZPX, M_ZPY, M_ABS, M_ABX, M_ABY, M_IZX, M_IZY
   } mode_type;

   typedef struct packed {
      kind_type kind;
      mode_type mode;
   } dec_type;

   localparam logic [7:0] RESET_SP = 8'hFD;
   localparam logic [7:0] RESET_P  = 8'h34;
   localparam logic [15:0] RESET_VEC = 16'hFFFC;

   function automatic mode_type alu_mode(input logic [2:0] b);
      case (b)
         3'd0: alu_mode = M_IZX;
         3'd1: alu_mode = M_ZP;
         3'd2: alu_mode = M_IMM;
         3'd3: alu_mode = M_ABS;
         3'd4: alu_mode = M_IZY;
         3'd5: alu_mode = M_ZPX;
         3'd6: alu_mode = M_ABY;
         default: alu_mode = M_ABX;
      endcase
   endfunction

   function automatic kind_type g0_kind(input logic [2:0] a);
      case (a)
         3'd1: g0_kind = K_BIT;
         3'd2: g0_kind = K_JMP;
         3'd3: g0_kind = K_JMPI;
         3'd4: g0_kind = K_STY;
         3'd5: g0_kind = K_LDY;
         3'd6: g0_kind = K_CPY;
         3'd7: g0_kind = K_CPX;
         default: g0_kind = K_BAD;
      endcase
   endfunction

   function automatic dec_type decode(input logic [7:0] op);
      logic [2:0] a, b;
      logic [1:0] c;
      kind_type k;
      dec_type r;
      a = op[7:5];
      b = op[4:2];
      c = op[1:0];
      r.kind = K_BAD;
      r.mode = M_IMP;
      k = kind_type'(6'(K_ASL) + 6'(a));
      case (c)
         2'd1: begin
            if (op != 8'h89) begin
               r.kind = kind_type'(6'(a));
               r.mode = alu_mode(b);
            end
         end
         2'd2: begin
            case (b)
               3'd0: if (op == 8'hA2) begin r.kind = K_LDX; r.mode = M_IMM; end
               3'd1: begin r.kind = k; r.mode = M_ZP; end
               3'd2: begin
                  if (a < 3'd4) begin r.kind = k; r.mode = M_ACC; end
                  else r.kind = K_IMPL;
               end
               3'd3: begin r.kind = k; r.mode = M_ABS; end
               3'd5: begin
                  r.kind = k;
                  r.mode = (a == 3'd4 || a == 3'd5) ? M_ZPY : M_ZPX;
               end
               3'd6: if (op == 8'h9A || op == 8'hBA) r.kind = K_IMPL;
               3'd7: if (a != 3'd4) begin
                  r.kind = k;
                  r.mode = (a == 3'd5) ? M_ABY : M_ABX;
               end
               default: ;
            endcase
         end
         2'd0: begin
            case (b)
               3'd0: begin
                  if (op == 8'h20) r.kind = K_JSR;
                  else if (op == 8'h40) r.kind = K_RTI;
                  else if (op == 8'h60) r.kind = K_RTS;
                  else if (a >= 3'd5) begin r.kind = g0_kind(a); r.mode = M_IMM; end
               end
               3'd1: if (a == 3'd1 || a >= 3'd4) begin
                  r.kind = g0_kind(a); r.mode = M_ZP;
               end
               3'd2: begin
                  case (a)
                     3'd0: r.kind = K_PHP;
                     3'd1: r.kind = K_PLP;
                     3'd2: r.kind = K_PHA;
                     3'd3: r.kind = K_PLA;
                     default: r.kind = K_IMPL;
                  endcase
               end
               3'd3: begin r.kind = g0_kind(a); r.mode = M_ABS; end
               3'd4: r.kind = K_BRANCH;
               3'd5: if (a == 3'd4 || a == 3'd5) begin
                  r.kind = g0_kind(a); r.mode = M_ZPX;
               end
               3'd6: r.kind = K_IMPL;
               default: if (a == 3'd5) begin r.kind = K_LDY; r.mode = M_ABX; end
            endcase
         end
         default: ;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] nz(input logic [7:0] p, input logic [7:0] v);
      return {v[7], p[6:2], (v == 8'h00), p[0]};
   endfunction

endpackage

### hw/rtl/ebc_decode.sv
// ebc_decode: opcode decode into kind and addressing mode
// depends on ebc_pkg
`timescale 1ns / 1ps
module ebc_decode (
   input  logic [7:0]       opcode,
   output ebc_pkg::dec_type dec
);
   import ebc_pkg::*;
   assign dec = decode(opcode);
endmodule

### hw/rtl/eight_bit_cpu_bus_cycle_core.sv
// eight_bit_cpu_bus_cycle_core: 6502-style core, one bus cycle per word
// depends on ebc_pkg, ebc_decode
//
//   channel | dir | tdata (low bit up)                          | tuser
//   req     | in  | read_data[7:0]                              | -
//   rsp     | out | bus_address[15:0] write_data[23:16]         | -
//           |     | write_enable[24] access_active[25]          |
//           |     | opcode_fetch[26] halted[27], zero to 32     |
//
// each req word advances the sequencer by one bus cycle; the rsp word for it
// is registered and appears in the next cycle, so one word per clock sustained
// while rsp_tready stays high; the core has a single result register
// synchronous reset restarts the start sequence
// the core only steps when a word is accepted; rsp stall holds the result and
// req_tready stays high whenever the result register is empty or being taken
`timescale 1ns / 1ps
module eight_bit_cpu_bus_cycle_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // read_data
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // bus_address, write_data, write_enable,
                                    // access_active, opcode_fetch, halted
);
   import ebc_pkg::*;

   // architectural registers
   logic [7:0]  a_ff, a_in, x_ff, x_in, y_ff, y_in, s_ff, s_in, p_ff, p_in;
   logic [15:0] pc_ff, pc_in, al_ff, al_in;
   logic [7:0]  op_ff, op_in, dl_ff, dl_in;
   logic [3:0]  t_ff, t_in;
   logic        jam_ff, jam_in, boot_ff, boot_in;
   logic        vld_ff;
   logic [31:0] out_ff, out_in;

   logic        step;
   logic [7:0]  d;
   dec_type     dec;
   logic [7:0]  cur_op;

   assign req_tready = !vld_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;
   assign rsp_tvalid = vld_ff;
   assign rsp_tdata  = out_ff;
   assign d          = req_tdata;
   assign cur_op     = (t_ff == 4'd1) ? d : op_ff;

   ebc_decode u_dec (.opcode(cur_op), .dec(dec));

   // bus cycle fields built up by the step logic
   logic [15:0] o_addr;
   logic [7:0]  o_data;
   logic        o_we, o_act, o_fetch;
   logic [3:0]  nxt;

   logic        cls_w, cls_rmw;
   logic [7:0]  idx, mv, mr, bin, opnd;
   logic        mc;
   logic [8:0]  sum, asum;
   logic [3:0]  tt;
   logic [15:0] tgt, part, offx;
   logic        bt;
   logic [1:0]  bsel;

   always_comb begin
      a_in = a_ff; x_in = x_ff; y_in = y_ff; s_in = s_ff; p_in = p_ff;
      pc_in = pc_ff; al_in = al_ff; op_in = op_ff; dl_in = dl_ff;
      t_in = t_ff; jam_in = jam_ff; boot_in = boot_ff;
      o_addr = 16'h0000; o_data = 8'h00; o_we = 1'b0; o_act = 1'b0; o_fetch = 1'b0;
      nxt = 4'd0;
      cls_w   = (dec.kind == K_STA) || (dec.kind == K_STX) || (dec.kind == K_STY);
      cls_rmw = (dec.kind == K_ASL) || (dec.kind == K_ROL) || (dec.kind == K_LSR) ||
                (dec.kind == K_ROR) || (dec.kind == K_DEC) || (dec.kind == K_INC);
      idx = (dec.mode == M_ZPY || dec.mode == M_ABY || dec.mode == M_IZY) ? y_ff : x_ff;
      sum = {1'b0, al_ff[7:0]} + {1'b0, idx};
      tt = t_ff;
      // read operand for modify: accumulator or latched memory byte
      mv = (dec.mode == M_ACC) ? a_ff : dl_ff;
      mc = p_ff[0];
      case (dec.kind)
         K_ASL:   begin mc = mv[7]; mr = {mv[6:0], 1'b0}; end
         K_ROL:   begin mc = mv[7]; mr = {mv[6:0], p_ff[0]}; end
         K_LSR:   begin mc = mv[0]; mr = {1'b0, mv[7:1]}; end
         K_ROR:   begin mc = mv[0]; mr = {p_ff[0], mv[7:1]}; end
         K_INC:   mr = mv + 8'd1;
         K_DEC:   mr = mv - 8'd1;
         default: mr = mv;
      endcase
      opnd = (dec.kind == K_SBC) ? ~d : d;
      asum = {1'b0, a_ff} + {1'b0, opnd} + {8'h00, p_ff[0]};
      bin  = 8'h00;
      bsel = cur_op[7:6];
      case (bsel)
         2'd0: bt = p_ff[7];
         2'd1: bt = p_ff[6];
         2'd2: bt = p_ff[0];
         default: bt = p_ff[1];
      endcase
      offx = {{8{dl_ff[7]}}, dl_ff};
      tgt  = pc_ff + offx;
      part = {pc_ff[15:8], pc_ff[7:0] + dl_ff};

      if (jam_ff) begin
         o_addr = pc_ff;
      end else if (boot_ff && t_ff < 4'd7) begin
         o_act = 1'b1;
         case (t_ff)
            4'd0: o_addr = 16'h0000;
            4'd1: o_addr = 16'h0001;
            4'd2, 4'd3, 4'd4: o_addr = {8'h01, s_ff - 8'(t_ff - 4'd2)};
            4'd5: o_addr = RESET_VEC;
            default: begin o_addr = RESET_VEC + 16'd1; al_in = {8'h00, d}; end
         endcase
         t_in = t_ff + 4'd1;
      end else begin
         if (boot_ff) begin
            pc_in = {d, al_ff[7:0]};
            boot_in = 1'b0;
         end else begin
            if (t_ff == 4'd1) op_in = d;
            if (t_ff == 4'd0) begin
               nxt = 4'd0;
            end else if (dec.kind == K_BAD) begin
               jam_in = 1'b1;
               o_addr = pc_ff;
            end else if (dec.mode == M_IMP || dec.mode == M_ACC) begin
               // implied, accumulator, stack, branch and jump sequences
               if (dec.kind == K_BRANCH) begin
                  if (t_ff == 4'd1) begin
                     o_act = 1'b1; o_addr = pc_ff; pc_in = pc_ff + 16'd1; nxt = 4'd2;
                  end else if (t_ff == 4'd2) begin
                     if (bt != cur_op[5]) nxt = 4'd0;
                     else begin dl_in = d; o_act = 1'b1; o_addr = pc_ff; nxt = 4'd3; end
                  end else if (t_ff == 4'd3) begin
                     pc_in = tgt;
                     if (tgt == part) nxt = 4'd0;
                     else begin o_act = 1'b1; o_addr = part; nxt = 4'd4; end
                  end
               end else if (dec.kind == K_JMP || dec.kind == K_JMPI) begin
                  if (t_ff == 4'd1 || t_ff == 4'd2) begin
                     if (t_ff == 4'd2) al_in = {8'h00, d};
                     o_act = 1'b1; o_addr = pc_ff; pc_in = pc_ff + 16'd1;
                     nxt = t_ff + 4'd1;
                  end else if (dec.kind == K_JMP) begin
                     if (t_ff == 4'd3) pc_in = {d, al_ff[7:0]};
                  end else if (t_ff == 4'd3) begin
                     al_in = {d, al_ff[7:0]}; o_act = 1'b1; o_addr = {d, al_ff[7:0]};
                     nxt = 4'd4;
                  end else if (t_ff == 4'd4) begin
                     dl_in = d; o_act = 1'b1;
                     o_addr = {al_ff[15:8], al_ff[7:0] + 8'd1}; nxt = 4'd5;
                  end else pc_in = {d, dl_ff};
               end else if (dec.kind == K_JSR) begin
                  o_act = 1'b1;
                  case (t_ff)
                     4'd1: begin o_addr = pc_ff; pc_in = pc_ff + 16'd1; nxt = 4'd2; end
                     4'd2: begin dl_in = d; o_addr = {8'h01, s_ff}; nxt = 4'd3; end
                     4'd3: begin
                        o_addr = {8'h01, s_ff}; o_we = 1'b1; o_data = pc_ff[15:8];
                        s_in = s_ff - 8'd1; nxt = 4'd4;
                     end
                     4'd4: begin
                        o_addr = {8'h01, s_ff}; o_we = 1'b1; o_data = pc_ff[7:0];
                        s_in = s_ff - 8'd1; nxt = 4'd5;
                     end
                     4'd5: begin o_addr = pc_ff; nxt = 4'd6; end
                     default: begin o_act = 1'b0; pc_in = {d, dl_ff}; end
                  endcase
               end else if (t_ff == 4'd1) begin
                  o_act = 1'b1; o_addr = pc_ff; nxt = 4'd2;
                  if (dec.kind == K_IMPL) begin
                     case (cur_op)
                        8'h8A: begin a_in = x_ff; p_in = nz(p_ff, x_ff); end
                        8'h98: begin a_in = y_ff; p_in = nz(p_ff, y_ff); end
                        8'hAA: begin x_in = a_ff; p_in = nz(p_ff, a_ff); end
                        8'hA8: begin y_in = a_ff; p_in = nz(p_ff, a_ff); end
                        8'hBA: begin x_in = s_ff; p_in = nz(p_ff, s_ff); end
                        8'h9A: s_in = x_ff;
                        8'hCA: begin x_in = x_ff - 8'd1; p_in = nz(p_ff, x_ff - 8'd1); end
                        8'hE8: begin x_in = x_ff + 8'd1; p_in = nz(p_ff, x_ff + 8'd1); end
                        8'h88: begin y_in = y_ff - 8'd1; p_in = nz(p_ff, y_ff - 8'd1); end
                        8'hC8: begin y_in = y_ff + 8'd1; p_in = nz(p_ff, y_ff + 8'd1); end
                        8'h18: p_in = p_ff & 8'hFE;
                        8'h38: p_in = p_ff | 8'h01;
                        8'h58: p_in = p_ff & 8'hFB;
                        8'h78: p_in = p_ff | 8'h04;
                        8'hB8: p_in = p_ff & 8'hBF;
                        8'hD8: p_in = p_ff & 8'hF7;
                        8'hF8: p_in = p_ff | 8'h08;
                        default: ;
                     endcase
                  end
                  if (dec.mode == M_ACC) begin
                     a_in = mr;
                     p_in = nz({p_ff[7:1], mc}, mr);
                  end
               end else if (dec.kind == K_PHA || dec.kind == K_PHP) begin
                  if (t_ff == 4'd2) begin
                     o_act = 1'b1; o_we = 1'b1; o_addr = {8'h01, s_ff};
                     o_data = (dec.kind == K_PHA) ? a_ff : (p_ff | 8'h30);
                     s_in = s_ff - 8'd1; nxt = 4'd3;
                  end
               end else if (dec.kind == K_PLA || dec.kind == K_PLP) begin
                  if (t_ff == 4'd2) begin
                     o_act = 1'b1; o_addr = {8'h01, s_ff}; s_in = s_ff + 8'd1; nxt = 4'd3;
                  end else if (t_ff == 4'd3) begin
                     o_act = 1'b1; o_addr = {8'h01, s_ff}; nxt = 4'd4;
                  end else if (dec.kind == K_PLA) begin
                     a_in = d; p_in = nz(p_ff, d);
                  end else p_in = (d & 8'hCF) | (p_ff & 8'h30);
               end else if (dec.kind == K_RTS || dec.kind == K_RTI) begin
                  if (t_ff == 4'd2 || t_ff == 4'd3) begin
                     o_act = 1'b1; o_addr = {8'h01, s_ff}; s_in = s_ff + 8'd1;
                     nxt = t_ff + 4'd1;
                  end else if (dec.kind == K_RTS) begin
                     if (t_ff == 4'd4) begin
                        dl_in = d; o_act = 1'b1; o_addr = {8'h01, s_ff}; nxt = 4'd5;
                     end else if (t_ff == 4'd5) begin
                        o_act = 1'b1; o_addr = {d, dl_ff}; pc_in = {d, dl_ff} + 16'd1;
                        nxt = 4'd6;
                     end
                  end else if (t_ff == 4'd4) begin
                     p_in = (d & 8'hCF) | (p_ff & 8'h30);
                     o_act = 1'b1; o_addr = {8'h01, s_ff}; s_in = s_ff + 8'd1; nxt = 4'd5;
                  end else if (t_ff == 4'd5) begin
                     dl_in = d; o_act = 1'b1; o_addr = {8'h01, s_ff}; nxt = 4'd6;
                  end else pc_in = {d, dl_ff};
               end
            end else begin
               // memory instructions: address phase, then data phase
               if (t_ff < TAIL) begin
                  tt = TAIL;
                  case (dec.mode)
                     M_IMM: begin
                        o_act = 1'b1; o_addr = pc_ff; pc_in = pc_ff + 16'd1;
                        tt = TAIL + 4'd1;
                     end
                     M_ZP: begin
                        if (t_ff == 4'd1) begin
                           o_act = 1'b1; o_addr = pc_ff; pc_in = pc_ff + 16'd1; tt = 4'd2;
                        end else al_in = {8'h00, d};
                     end
                     M_ZPX, M_ZPY: begin
                        if (t_ff == 4'd1) begin
                           o_act = 1'b1; o_addr = pc_ff; pc_in = pc_ff + 16'd1; tt = 4'd2;
                        end else if (t_ff == 4'd2) begin
                           al_in = {8'h00, d}; o_act = 1'b1; o_addr = {8'h00, d}; tt = 4'd3;
                        end else al_in = {8'h00, al_ff[7:0] + idx};
                     end
                     M_ABS, M_ABX, M_ABY: begin
                        if (t_ff == 4'd1 || t_ff == 4'd2) begin
                           if (t_ff == 4'd2) al_in = {8'h00, d};
                           o_act = 1'b1; o_addr = pc_ff; pc_in = pc_ff + 16'd1;
                           tt = t_ff + 4'd1;
                        end else if (dec.mode == M_ABS) begin
                           al_in = {d, al_ff[7:0]};
                        end else if (t_ff == 4'd3) begin
                           al_in = {d, 8'h00} + {8'h00, al_ff[7:0]} + {8'h00, idx};
                           if (sum[8] || cls_w || cls_rmw) begin
                              o_act = 1'b1; o_addr = {d, sum[7:0]}; tt = 4'd4;
                           end
                        end
                     end
                     M_IZX: begin
                        o_act = 1'b1;
                        case (t_ff)
                           4'd1: begin o_addr = pc_ff; pc_in = pc_ff + 16'd1; tt = 4'd2; end
                           4'd2: begin dl_in = d; o_addr = {8'h00, d}; tt = 4'd3; end
                           4'd3: begin
                              dl_in = dl_ff + x_ff; o_addr = {8'h00, dl_ff + x_ff}; tt = 4'd4;
                           end
                           4'd4: begin
                              al_in = {8'h00, d}; o_addr = {8'h00, dl_ff + 8'd1}; tt = 4'd5;
                           end
                           default: begin o_act = 1'b0; al_in = {d, al_ff[7:0]}; end
                        endcase
                     end
                     default: begin
                        // indirect indexed by y
                        o_act = 1'b1;
                        case (t_ff)
                           4'd1: begin o_addr = pc_ff; pc_in = pc_ff + 16'd1; tt = 4'd2; end
                           4'd2: begin dl_in = d; o_addr = {8'h00, d}; tt = 4'd3; end
                           4'd3: begin
                              al_in = {8'h00, d}; o_addr = {8'h00, dl_ff + 8'd1}; tt = 4'd4;
                           end
                           4'd4: begin
                              o_act = 1'b0;
                              al_in = {d, 8'h00} + {8'h00, al_ff[7:0]} + {8'h00, idx};
                              if (sum[8] || cls_w || cls_rmw) begin
                                 o_act = 1'b1; o_addr = {d, sum[7:0]}; tt = 4'd5;
                              end
                           end
                           default: o_act = 1'b0;
                        endcase
                     end
                  endcase
                  nxt = tt;
               end
               if (tt == TAIL) begin
                  // al_in already holds the effective address
                  o_act = 1'b1; o_addr = al_in;
                  if (cls_w) begin
                     o_we = 1'b1;
                     o_data = (dec.kind == K_STA) ? a_ff : (dec.kind == K_STX) ? x_ff : y_ff;
                  end
                  nxt = TAIL + 4'd1;
               end else if (t_ff == TAIL + 4'd1) begin
                  nxt = 4'd0;
                  if (cls_rmw) begin
                     dl_in = d; o_act = 1'b1; o_we = 1'b1; o_addr = al_ff; o_data = d;
                     nxt = TAIL + 4'd2;
                  end else if (!cls_w) begin
                     case (dec.kind)
                        K_ORA: begin a_in = a_ff | d; p_in = nz(p_ff, a_ff | d); end
                        K_AND: begin a_in = a_ff & d; p_in = nz(p_ff, a_ff & d); end
                        K_EOR: begin a_in = a_ff ^ d; p_in = nz(p_ff, a_ff ^ d); end
                        K_LDA: begin a_in = d; p_in = nz(p_ff, d); end
                        K_LDX: begin x_in = d; p_in = nz(p_ff, d); end
                        K_LDY: begin y_in = d; p_in = nz(p_ff, d); end
                        K_CMP, K_CPX, K_CPY: begin
                           bin = (dec.kind == K_CMP) ? a_ff : (dec.kind == K_CPX) ? x_ff : y_ff;
                           p_in = nz({p_ff[7:1], bin >= d}, bin - d);
                        end
                        K_ADC, K_SBC: begin
                           a_in = asum[7:0];
                           p_in = nz({p_ff[7],
                                      (~(a_ff[7] ^ opnd[7])) & (a_ff[7] ^ asum[7]),
                                      p_ff[5:1], asum[8]}, asum[7:0]);
                        end
                        K_BIT: p_in = {d[7:6], p_ff[5:2], ((a_ff & d) == 8'h00), p_ff[0]};
                        default: ;
                     endcase
                  end
               end else if (t_ff == TAIL + 4'd2 && cls_rmw) begin
                  dl_in = mr; p_in = nz({p_ff[7:1], mc}, mr);
                  o_act = 1'b1; o_we = 1'b1; o_addr = al_ff; o_data = mr;
                  nxt = TAIL + 4'd3;
               end else if (t_ff >= TAIL + 4'd2) nxt = 4'd0;
            end
         end
         if (!jam_in) begin
            if (nxt == 4'd0) begin
               o_act = 1'b1; o_we = 1'b0; o_data = 8'h00; o_fetch = 1'b1;
               o_addr = pc_in; pc_in = pc_in + 16'd1; nxt = 4'd1;
            end
            t_in = nxt;
         end
      end
      out_in = {4'h0, jam_in, o_fetch, o_act, o_we, o_data, o_addr};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff <= 8'h00; x_ff <= 8'h00; y_ff <= 8'h00;
         s_ff <= RESET_SP; p_ff <= RESET_P;
         pc_ff <= 16'h0000; al_ff <= 16'h0000; op_ff <= 8'h00; dl_ff <= 8'h00;
         t_ff <= 4'd0; jam_ff <= 1'b0; boot_ff <= 1'b1; vld_ff <= 1'b0;
      end else begin
         if (step) begin
            a_ff <= a_in; x_ff <= x_in; y_ff <= y_in; s_ff <= s_in; p_ff <= p_in;
            pc_ff <= pc_in; al_ff <= al_in; op_ff <= op_in; dl_ff <= dl_in;
            t_ff <= t_in; jam_ff <= jam_in; boot_ff <= boot_in;
         end
         if (step) vld_ff <= 1'b1;
         else if (rsp_tready) vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) out_ff <= out_in;
   end

   // a jammed core stays jammed
   assert property (@(posedge clock) disable iff (reset) jam_ff |=> jam_ff)
      else $error("jam flag cleared without reset");
   // results while jammed are idle cycles
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[27]) |-> (rsp_tdata[25] == 1'b0))
      else $error("jammed core issued a bus access");
   // a write never fetches an opcode
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[24] && rsp_tdata[26]))
      else $error("write cycle marked as opcode fetch");

endmodule
